[src/oximeter_led_drive_adjuster_core_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the LED drive adjuster
// Two helpers for concurrent checks: a same-cycle implication and a
// next-cycle implication, both clocked on the rising edge.
// ---------------------------------------------------------------------------
`ifndef OXIMETER_LED_DRIVE_ADJUSTER_CORE_ASSERT_SVH
`define OXIMETER_LED_DRIVE_ADJUSTER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OLDAC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("oldac assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define OLDAC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("oldac assertion failed");

`endif

[src/oldac_pkg.sv]
// ---------------------------------------------------------------------------
// LED drive adjuster package
// Shared widths, register map, reset values, word types and helpers.
// ---------------------------------------------------------------------------
package oldac_pkg;

   // Field widths
   localparam int SAMPLE_WIDTH  = 12;
   localparam int BAND_WIDTH    = 11;
   localparam int SETTLE_WIDTH  = 6;
   localparam int CNT_WIDTH     = 2;
   localparam int CONFIRM_COUNT = 3;

   localparam logic [SAMPLE_WIDTH-1:0] DRIVE_MAX = '1;
   localparam logic [CNT_WIDTH-1:0]    CNT_MAX   = '1;
   localparam logic [SETTLE_WIDTH-1:0] SETTLE_MAX = '1;
   localparam logic [CNT_WIDTH-1:0]    CONFIRM   = CNT_WIDTH'(CONFIRM_COUNT);

   // Register map, index is the byte address divided by four
   localparam int CSR_ADDR_WIDTH = 5;
   localparam logic [2:0] REG_OFF_LEVEL    = 3'd0;
   localparam logic [2:0] REG_IR_TARGET    = 3'd1;
   localparam logic [2:0] REG_RED_TARGET   = 3'd2;
   localparam logic [2:0] REG_DRIVE_START  = 3'd3;
   localparam logic [2:0] REG_DRIVE_LIMIT  = 3'd4;
   localparam logic [2:0] REG_FINE_OFFSET  = 3'd5;
   localparam logic [2:0] REG_BAND_HALF    = 3'd6;
   localparam logic [2:0] REG_SETTLE_COUNT = 3'd7;

   // Register reset values
   localparam logic [SAMPLE_WIDTH-1:0] RST_OFF_LEVEL    = 12'd80;
   localparam logic [SAMPLE_WIDTH-1:0] RST_IR_TARGET    = 12'd2000;
   localparam logic [SAMPLE_WIDTH-1:0] RST_RED_TARGET   = 12'd1700;
   localparam logic [SAMPLE_WIDTH-1:0] RST_DRIVE_START  = 12'd100;
   localparam logic [SAMPLE_WIDTH-1:0] RST_DRIVE_LIMIT  = 12'd250;
   localparam logic [BAND_WIDTH-1:0]   RST_FINE_OFFSET  = 11'd300;
   localparam logic [BAND_WIDTH-1:0]   RST_BAND_HALF    = 11'd500;
   localparam logic [SETTLE_WIDTH-1:0] RST_SETTLE_COUNT = 6'd20;
   localparam logic [SAMPLE_WIDTH-1:0] RST_DRIVE_LEVEL  = 12'd100;

   // Phase codes
   localparam logic [1:0] PHASE_WAIT   = 2'd0;
   localparam logic [1:0] PHASE_COARSE = 2'd1;
   localparam logic [1:0] PHASE_LOCKED = 2'd2;

   // Channel positions inside the two-bit flag vectors
   localparam int CH_IR  = 0;
   localparam int CH_RED = 1;

   typedef logic [SAMPLE_WIDTH-1:0] sample_type;

   typedef struct packed {
      sample_type                off_level;
      sample_type                ir_target;
      sample_type                red_target;
      sample_type                drive_start;
      sample_type                drive_limit;
      logic [BAND_WIDTH-1:0]     fine_offset;
      logic [BAND_WIDTH-1:0]     band_half;
      logic [SETTLE_WIDTH-1:0]   settle_count;
   } cfg_type;

   // Classified word passed from the front end to the back end
   typedef struct packed {
      logic       low;
      logic       above_off;
      logic [1:0] below;
      logic [1:0] band_out;
      logic [1:0] fine_hi;
      logic [1:0] fine_lo;
   } item_type;

   function automatic logic [CNT_WIDTH-1:0] sat_cnt(logic [CNT_WIDTH-1:0] v);
      return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
   endfunction

   function automatic logic [SETTLE_WIDTH-1:0] sat_settle(logic [SETTLE_WIDTH-1:0] v);
      return (v == SETTLE_MAX) ? SETTLE_MAX : v + 1'b1;
   endfunction

endpackage

[src/oldac_ifs.sv]
// ---------------------------------------------------------------------------
// LED drive adjuster channel interfaces
// Valid/ready channels for the sample word and the drive result word.
// ---------------------------------------------------------------------------
interface oldac_req_if import oldac_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type ir_sample;
   sample_type red_sample;
   sample_type ir_average;
   sample_type red_average;

   modport source (output valid, ir_sample, red_sample, ir_average, red_average,
                   input ready);
   modport sink   (input valid, ir_sample, red_sample, ir_average, red_average,
                   output ready);
endinterface

interface oldac_rsp_if import oldac_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type ir_drive;
   sample_type red_drive;
   logic       ir_drive_written;
   logic       red_drive_written;
   logic       finger_on;
   logic [1:0] phase;

   modport source (output valid, ir_drive, red_drive, ir_drive_written,
                   red_drive_written, finger_on, phase, input ready);
   modport sink   (input valid, ir_drive, red_drive, ir_drive_written,
                   red_drive_written, finger_on, phase, output ready);
endinterface

[src/oldac_front.sv]
// ---------------------------------------------------------------------------
// LED drive adjuster front end
// Accepts sample words and reduces them to threshold flags for the back end.
// ---------------------------------------------------------------------------
module oldac_front import oldac_pkg::*; (
   oldac_req_if.sink req_if,
   input  cfg_type   cfg,
   input  logic      q_full,
   output logic      push,
   output item_type  push_item
);

   // Average strictly above target plus half width.
   function automatic logic above_band(sample_type a, sample_type t,
                                       logic [BAND_WIDTH-1:0] b);
      return {1'b0, a} > ({1'b0, t} + {2'b00, b});
   endfunction

   // Average strictly below target minus half width, kept non-negative.
   function automatic logic below_band(sample_type a, sample_type t,
                                       logic [BAND_WIDTH-1:0] b);
      return ({1'b0, a} + {2'b00, b}) < {1'b0, t};
   endfunction

   assign req_if.ready = !q_full;
   assign push         = req_if.valid && !q_full;

   // Classification against the configured levels.
   always_comb begin
      push_item.low       = (req_if.ir_sample < cfg.off_level) ||
                            (req_if.red_sample < cfg.off_level);
      push_item.above_off = (req_if.ir_sample > cfg.off_level) ||
                            (req_if.red_sample > cfg.off_level);
      push_item.below[CH_IR]  = req_if.ir_sample < cfg.ir_target;
      push_item.below[CH_RED] = req_if.red_sample < cfg.red_target;
      push_item.band_out[CH_IR] =
         above_band(req_if.ir_average, cfg.ir_target, cfg.band_half) ||
         below_band(req_if.ir_average, cfg.ir_target, cfg.band_half);
      push_item.band_out[CH_RED] =
         above_band(req_if.red_average, cfg.red_target, cfg.band_half) ||
         below_band(req_if.red_average, cfg.red_target, cfg.band_half);
      push_item.fine_hi[CH_IR]  =
         above_band(req_if.ir_average, cfg.ir_target, cfg.fine_offset);
      push_item.fine_hi[CH_RED] =
         above_band(req_if.red_average, cfg.red_target, cfg.fine_offset);
      push_item.fine_lo[CH_IR]  =
         below_band(req_if.ir_average, cfg.ir_target, cfg.fine_offset);
      push_item.fine_lo[CH_RED] =
         below_band(req_if.red_average, cfg.red_target, cfg.fine_offset);
   end

endmodule

[src/oldac_queue.sv]
// ---------------------------------------------------------------------------
// LED drive adjuster word queue
// Two-entry queue that decouples the front end from the back end.
// ---------------------------------------------------------------------------
module oldac_queue import oldac_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output logic     q_valid,
   output logic     q_full,
   output item_type pop_item
);

   item_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign q_valid  = (cnt_ff != 2'd0);
   assign q_full   = (cnt_ff == 2'd2);
   assign pop_item = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[src/oldac_back.sv]
// ---------------------------------------------------------------------------
// LED drive adjuster back end
// Holds the finger and lock state, updates the drive levels once per word
// and presents the result in an output register.
// ---------------------------------------------------------------------------
module oldac_back import oldac_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       q_valid,
   input  item_type   pop_item,
   output logic       pop,
   oldac_rsp_if.source rsp_if
);

   typedef struct packed {
      logic                  locked;
      logic [CNT_WIDTH-1:0]  lock_cnt;
      logic [CNT_WIDTH-1:0]  delay_cnt;
      logic [CNT_WIDTH-1:0]  out_cnt;
      sample_type            level;
   } chan_type;

   typedef struct packed {
      chan_type [1:0]          ch;
      logic                    seen;
      logic                    flag;
      logic [SETTLE_WIDTH-1:0] off_cnt;
      logic [SETTLE_WIDTH-1:0] on_cnt;
   } state_type;

   state_type  st_ff, st_in;
   logic       out_valid_ff, out_valid_in;
   sample_type ir_drive_ff, ir_drive_in;
   sample_type red_drive_ff, red_drive_in;
   logic       ir_wr_ff, ir_wr_in;
   logic       red_wr_ff, red_wr_in;
   logic       finger_ff, finger_in;
   logic [1:0] phase_ff, phase_in;

   // State after reset: everything clear, both drives at their reset level.
   function automatic state_type reset_state();
      state_type r;
      r                  = '0;
      r.ch[CH_IR].level  = RST_DRIVE_LEVEL;
      r.ch[CH_RED].level = RST_DRIVE_LEVEL;
      return r;
   endfunction

   // Restart keeps the delay counts.
   function automatic chan_type chan_restart(chan_type c, sample_type start);
      chan_type r;
      r          = c;
      r.locked   = 1'b0;
      r.lock_cnt = '0;
      r.out_cnt  = '0;
      r.level    = start;
      return r;
   endfunction

   function automatic state_type do_restart(state_type s, cfg_type c);
      state_type r;
      r         = s;
      r.ch[CH_IR]  = chan_restart(s.ch[CH_IR], c.drive_start);
      r.ch[CH_RED] = chan_restart(s.ch[CH_RED], c.drive_start);
      r.seen    = 1'b0;
      r.off_cnt = '0;
      r.on_cnt  = '0;
      return r;
   endfunction

   function automatic state_type count_off(state_type s, cfg_type c);
      state_type r;
      r         = s;
      r.off_cnt = sat_settle(s.off_cnt);
      if (r.off_cnt >= c.settle_count) begin
         r      = do_restart(r, c);
         r.flag = 1'b0;
      end
      return r;
   endfunction

   // One coarse step for one channel; a restart touches both channels.
   function automatic state_type coarse(state_type s, cfg_type c, logic red_ch,
                                        logic below);
      state_type r;
      chan_type  ch;
      r  = s;
      ch = red_ch ? s.ch[CH_RED] : s.ch[CH_IR];
      if (!ch.locked) begin
         if (below) begin
            ch.lock_cnt = sat_cnt(ch.lock_cnt);
            if (ch.lock_cnt >= CONFIRM) begin
               ch.locked = 1'b1;
            end
         end else begin
            ch.delay_cnt = sat_cnt(ch.delay_cnt);
            if (ch.delay_cnt >= CONFIRM) begin
               ch.delay_cnt = '0;
               if (ch.level < c.drive_limit) begin
                  ch.level = (ch.level >= DRIVE_MAX - 1'b1) ? DRIVE_MAX
                                                            : ch.level + 2'd2;
               end else begin
                  if (red_ch) begin
                     r.ch[CH_RED] = ch;
                  end else begin
                     r.ch[CH_IR] = ch;
                  end
                  r  = do_restart(r, c);
                  ch = red_ch ? r.ch[CH_RED] : r.ch[CH_IR];
               end
               ch.lock_cnt = '0;
            end
         end
      end
      if (red_ch) begin
         r.ch[CH_RED] = ch;
      end else begin
         r.ch[CH_IR] = ch;
      end
      return r;
   endfunction

   function automatic chan_type band_check(chan_type c, logic out);
      chan_type r;
      r = c;
      if (out) begin
         r.out_cnt = sat_cnt(c.out_cnt);
         if (r.out_cnt >= CONFIRM) begin
            r.locked  = 1'b0;
            r.out_cnt = '0;
         end
      end else begin
         r.out_cnt = '0;
      end
      return r;
   endfunction

   function automatic chan_type fine_trim(chan_type c, logic hi, logic lo);
      chan_type r;
      r = c;
      if (hi) begin
         if (c.level != DRIVE_MAX) begin
            r.level = c.level + 1'b1;
         end
      end else if (lo) begin
         if (c.level != '0) begin
            r.level = c.level - 1'b1;
         end
      end
      return r;
   endfunction

   // A word moves on when the output register is free or being emptied.
   assign pop = q_valid && (!out_valid_ff || rsp_if.ready);

   // State update for one word.
   always_comb begin
      st_in = st_ff;
      if (pop_item.low) begin
         st_in = count_off(st_in, cfg);
      end
      if (st_in.ch[CH_IR].locked && st_in.ch[CH_RED].locked) begin
         st_in.ch[CH_IR]  = band_check(st_in.ch[CH_IR], pop_item.band_out[CH_IR]);
         st_in.ch[CH_RED] = band_check(st_in.ch[CH_RED], pop_item.band_out[CH_RED]);
         if (st_in.ch[CH_IR].locked && st_in.ch[CH_RED].locked) begin
            st_in.ch[CH_IR]  = fine_trim(st_in.ch[CH_IR], pop_item.fine_hi[CH_IR],
                                         pop_item.fine_lo[CH_IR]);
            st_in.ch[CH_RED] = fine_trim(st_in.ch[CH_RED], pop_item.fine_hi[CH_RED],
                                         pop_item.fine_lo[CH_RED]);
         end
      end else if (st_in.seen) begin
         if (pop_item.low) begin
            st_in = count_off(st_in, cfg);
         end else begin
            st_in.off_cnt = '0;
            st_in.flag    = 1'b1;
            if (st_in.on_cnt < cfg.settle_count) begin
               st_in.on_cnt = sat_settle(st_in.on_cnt);
            end else begin
               st_in = coarse(st_in, cfg, 1'b0, pop_item.below[CH_IR]);
               st_in = coarse(st_in, cfg, 1'b1, pop_item.below[CH_RED]);
            end
         end
      end else begin
         if (pop_item.above_off) begin
            st_in.on_cnt = '0;
            st_in.seen   = 1'b1;
         end
         st_in.ch[CH_IR].level  = cfg.drive_start;
         st_in.ch[CH_RED].level = cfg.drive_start;
      end
   end

   // Result word built from the updated state.
   always_comb begin
      out_valid_in = pop || (out_valid_ff && !rsp_if.ready);
      ir_drive_in  = st_in.ch[CH_IR].level;
      red_drive_in = st_in.ch[CH_RED].level;
      ir_wr_in     = st_in.ch[CH_IR].level != st_ff.ch[CH_IR].level;
      red_wr_in    = st_in.ch[CH_RED].level != st_ff.ch[CH_RED].level;
      finger_in    = st_in.flag;
      if (st_in.ch[CH_IR].locked && st_in.ch[CH_RED].locked) begin
         phase_in = PHASE_LOCKED;
      end else if (st_in.seen) begin
         phase_in = PHASE_COARSE;
      end else begin
         phase_in = PHASE_WAIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= reset_state();
         out_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            st_ff <= st_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   // Output payload registers load whenever a word moves on.
   always_ff @(posedge clock) begin
      if (pop) begin
         ir_drive_ff  <= ir_drive_in;
         red_drive_ff <= red_drive_in;
         ir_wr_ff     <= ir_wr_in;
         red_wr_ff    <= red_wr_in;
         finger_ff    <= finger_in;
         phase_ff     <= phase_in;
      end
   end

   assign rsp_if.valid             = out_valid_ff;
   assign rsp_if.ir_drive          = ir_drive_ff;
   assign rsp_if.red_drive         = red_drive_ff;
   assign rsp_if.ir_drive_written  = ir_wr_ff;
   assign rsp_if.red_drive_written = red_wr_ff;
   assign rsp_if.finger_on         = finger_ff;
   assign rsp_if.phase             = phase_ff;

endmodule

[src/oximeter_led_drive_adjuster_core.sv]
// ---------------------------------------------------------------------------
// Oximeter LED drive adjuster, top level
// Path: a word accepted on the input passes through the two-entry queue and
// then the back end's output register before it is on the result port.
// Throughput: one word per cycle unless the result port stalls.
// The two-entry queue lets the input run on while the result waits.
// Reset: synchronous, clears state, levels to 100 and registers to defaults.
// ---------------------------------------------------------------------------
module oximeter_led_drive_adjuster_core import oldac_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   oldac_req_if.sink                 req_if,
   oldac_rsp_if.source               rsp_if,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] csr_idx;
   logic       csr_wr;
   logic       push, pop, q_valid, q_full;
   item_type   push_item, pop_item;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_ADDR_WIDTH-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_OFF_LEVEL:    cfg_in.off_level    = csr_pwdata[SAMPLE_WIDTH-1:0];
            REG_IR_TARGET:    cfg_in.ir_target    = csr_pwdata[SAMPLE_WIDTH-1:0];
            REG_RED_TARGET:   cfg_in.red_target   = csr_pwdata[SAMPLE_WIDTH-1:0];
            REG_DRIVE_START:  cfg_in.drive_start  = csr_pwdata[SAMPLE_WIDTH-1:0];
            REG_DRIVE_LIMIT:  cfg_in.drive_limit  = csr_pwdata[SAMPLE_WIDTH-1:0];
            REG_FINE_OFFSET:  cfg_in.fine_offset  = csr_pwdata[BAND_WIDTH-1:0];
            REG_BAND_HALF:    cfg_in.band_half    = csr_pwdata[BAND_WIDTH-1:0];
            REG_SETTLE_COUNT: cfg_in.settle_count = csr_pwdata[SETTLE_WIDTH-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      unique case (csr_idx)
         REG_OFF_LEVEL:    csr_prdata = 32'(cfg_ff.off_level);
         REG_IR_TARGET:    csr_prdata = 32'(cfg_ff.ir_target);
         REG_RED_TARGET:   csr_prdata = 32'(cfg_ff.red_target);
         REG_DRIVE_START:  csr_prdata = 32'(cfg_ff.drive_start);
         REG_DRIVE_LIMIT:  csr_prdata = 32'(cfg_ff.drive_limit);
         REG_FINE_OFFSET:  csr_prdata = 32'(cfg_ff.fine_offset);
         REG_BAND_HALF:    csr_prdata = 32'(cfg_ff.band_half);
         REG_SETTLE_COUNT: csr_prdata = 32'(cfg_ff.settle_count);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.off_level    <= RST_OFF_LEVEL;
         cfg_ff.ir_target    <= RST_IR_TARGET;
         cfg_ff.red_target   <= RST_RED_TARGET;
         cfg_ff.drive_start  <= RST_DRIVE_START;
         cfg_ff.drive_limit  <= RST_DRIVE_LIMIT;
         cfg_ff.fine_offset  <= RST_FINE_OFFSET;
         cfg_ff.band_half    <= RST_BAND_HALF;
         cfg_ff.settle_count <= RST_SETTLE_COUNT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   oldac_front u_front (
      .req_if    (req_if),
      .cfg       (cfg_ff),
      .q_full    (q_full),
      .push      (push),
      .push_item (push_item)
   );

   oldac_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .q_valid   (q_valid),
      .q_full    (q_full),
      .pop_item  (pop_item)
   );

   oldac_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_valid  (q_valid),
      .pop_item (pop_item),
      .pop      (pop),
      .rsp_if   (rsp_if)
   );

endmodule

[src/oldac_checker.sv]
// ---------------------------------------------------------------------------
// LED drive adjuster port checker
// Watches the result channel of the top level over time.
// ---------------------------------------------------------------------------
`include "oximeter_led_drive_adjuster_core_assert.svh"

module oldac_checker import oldac_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input sample_type rsp_ir_drive,
   input sample_type rsp_red_drive,
   input logic       rsp_ir_written,
   input logic       rsp_red_written,
   input logic       rsp_finger_on,
   input logic [1:0] rsp_phase
);

   // A stalled result word holds until taken.
   `OLDAC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable({rsp_ir_drive, rsp_red_drive, rsp_ir_written,
                            rsp_red_written, rsp_finger_on, rsp_phase}))

   // The phase never takes the unused code.
   `OLDAC_ASSERT_IMP(a_phase_code, clock, reset, rsp_valid,
      rsp_phase == PHASE_WAIT || rsp_phase == PHASE_COARSE ||
      rsp_phase == PHASE_LOCKED)

   // Both channels can only be locked with a finger present.
   `OLDAC_ASSERT_IMP(a_lock_finger, clock, reset,
      rsp_valid && rsp_phase == PHASE_LOCKED, rsp_finger_on)

   // No result word is offered straight after reset.
   `OLDAC_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind oximeter_led_drive_adjuster_core oldac_checker u_oldac_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_ir_drive    (rsp_if.ir_drive),
   .rsp_red_drive   (rsp_if.red_drive),
   .rsp_ir_written  (rsp_if.ir_drive_written),
   .rsp_red_written (rsp_if.red_drive_written),
   .rsp_finger_on   (rsp_if.finger_on),
   .rsp_phase       (rsp_if.phase)
);
